@@ rtl/core/pi_speed_loop_dual_motor_defines.svh @@
// assertion macros shared by the speed loop rtl
`ifndef PI_SPEED_LOOP_DUAL_MOTOR_DEFINES_SVH
`define PI_SPEED_LOOP_DUAL_MOTOR_DEFINES_SVH

// condition that holds at every edge out of reset
`define PSL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define PSL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/psl_pkg.sv @@
// shared types, widths and constants of the dual motor speed loop
package psl_pkg;

  // field widths
  localparam int CNT_W      = 16;
  localparam int SET_W      = 12;
  localparam int STEER_W    = 11;
  localparam int GAIN_W     = 10;
  localparam int LIMIT_W    = 12;
  localparam int MARGIN_W   = 10;
  localparam int DZ_W       = 8;
  localparam int DRV_W      = 10;
  localparam int SPD_OUT_W  = 11;
  localparam int CV_W       = 16;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  // internal widths, sized for the largest allowed speed clamp
  localparam int SUM_W     = 18;
  localparam int SPD_W     = 13;
  localparam int ERR_W     = 14;
  localparam int PPROD_W   = ERR_W + GAIN_W + 1;
  localparam int INTEG_W   = 24;
  localparam int CTRL_W    = 28;

  // scaling in thousandths
  localparam int MILLI       = 1000;
  localparam int PGAIN_SCALE = 10;
  localparam int INTEG_MAX   = 4095000;

  // drive magnitude: clamp then divide by 1000 through a reciprocal
  localparam int DRV_ABS_W   = 21;
  localparam int DRV_ABS_MAX = 1024000;
  localparam int DRV_RECIP   = 2147484;
  localparam int DRV_RECIP_W = 22;
  localparam int DRV_SHIFT   = 31;
  localparam int DRV_Q_W     = 11;

  // control value: clamp then divide by 1000 through a reciprocal
  localparam int CV_ABS_W   = 25;
  localparam int CV_ABS_MAX = 32768000;
  localparam int CV_RECIP   = 34359739;
  localparam int CV_RECIP_W = 26;
  localparam int CV_SHIFT   = 35;
  localparam int CV_Q_W     = 16;
  localparam int CV_POS_MAX = 32767;

  localparam int DEF_SPEED_CLAMP = 1000;

  // register reset values
  localparam logic [GAIN_W-1:0]   RST_PROP_GAIN  = 10'd190;
  localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN = 10'd5;
  localparam logic [LIMIT_W-1:0]  RST_INTEG_LIM  = 12'd800;
  localparam logic [MARGIN_W-1:0] RST_MARGIN     = 10'd30;
  localparam logic [DZ_W-1:0]     RST_LEFT_DZ    = 8'd60;
  localparam logic [DZ_W-1:0]     RST_RIGHT_DZ   = 8'd30;
  localparam logic [DRV_W-1:0]    RST_MAX_FWD    = 10'd980;
  localparam logic [DRV_W-1:0]    RST_MAX_REV    = 10'd900;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_INTEG_LIM  = 3'd2,
    REG_MARGIN     = 3'd3,
    REG_LEFT_DZ    = 3'd4,
    REG_RIGHT_DZ   = 3'd5,
    REG_MAX_FWD    = 3'd6,
    REG_MAX_REV    = 3'd7
  } cfg_reg_t;

  // configuration register set
  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [LIMIT_W-1:0]  integ_limit;
    logic [MARGIN_W-1:0] overspeed_margin;
    logic [DZ_W-1:0]     left_deadzone;
    logic [DZ_W-1:0]     right_deadzone;
    logic [DRV_W-1:0]    max_forward;
    logic [DRV_W-1:0]    max_reverse;
  } psl_cfg_t;

  // per-stage load enables and the integral update strobe
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld6;
    logic integ_upd;
  } psl_ctl_t;

endpackage

@@ rtl/core/psl_pi_core.sv @@
// speed measurement, error, clamped integral and pi sum (stages 2 and 3)
`include "pi_speed_loop_dual_motor_defines.svh"

module psl_pi_core
  import psl_pkg::*;
#(
  parameter int SPEED_CLAMP = DEF_SPEED_CLAMP
) (
  input  logic                     clk,
  input  logic                     rst,
  input  psl_ctl_t                 ctl,
  input  psl_cfg_t                 cfg,
  input  logic signed [CNT_W-1:0]  left_count,
  input  logic signed [CNT_W-1:0]  right_count,
  input  logic signed [SET_W-1:0]  set_speed,
  output logic signed [CTRL_W-1:0] ctrl,
  output logic signed [SPD_W-1:0]  speed
);

  localparam logic signed [SUM_W-1:0]   CLAMP_HI = SUM_W'(SPEED_CLAMP);
  localparam logic signed [SUM_W-1:0]   CLAMP_LO = -CLAMP_HI;
  localparam logic signed [CTRL_W-1:0]  MILLI_S  = CTRL_W'(MILLI);
  localparam logic signed [CTRL_W-1:0]  PSCALE_S = CTRL_W'(PGAIN_SCALE);
  localparam logic signed [INTEG_W-1:0] INTEG_HI = INTEG_W'(INTEG_MAX);

  logic signed [SUM_W-1:0]   sum;
  logic signed [SPD_W-1:0]   speed_c;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] iprod;
  logic signed [INTEG_W:0]   isum;
  logic [INTEG_W-1:0]        lim_u;
  logic signed [INTEG_W:0]   lim_s;
  logic signed [INTEG_W-1:0] integral_next;
  logic signed [PPROD_W-1:0] pprod_c;
  logic                      over_c;

  logic signed [INTEG_W-1:0] integral;
  logic signed [SET_W-1:0]   set2;
  logic signed [SPD_W-1:0]   speed2;
  logic signed [PPROD_W-1:0] pprod2;
  logic                      over2;

  // negated count sum, clamped
  always_comb begin
    sum = -SUM_W'(left_count) - SUM_W'(right_count);
    if (sum > CLAMP_HI) begin
      speed_c = SPD_W'(CLAMP_HI);
    end else if (sum < CLAMP_LO) begin
      speed_c = SPD_W'(CLAMP_LO);
    end else begin
      speed_c = SPD_W'(sum);
    end
    err = ERR_W'(set_speed) - ERR_W'(speed_c);
  end

  // integral step and clamp against the limit in thousandths
  always_comb begin
    iprod = INTEG_W'(err) * INTEG_W'($signed({1'b0, cfg.integ_gain}));
    isum  = (INTEG_W+1)'(integral) + (INTEG_W+1)'(iprod);
    lim_u = INTEG_W'(cfg.integ_limit) * INTEG_W'(MILLI);
    lim_s = $signed({1'b0, lim_u});
    if (isum > lim_s) begin
      integral_next = INTEG_W'(lim_s);
    end else if (isum < -lim_s) begin
      integral_next = INTEG_W'(-lim_s);
    end else begin
      integral_next = INTEG_W'(isum);
    end
  end

  // proportional product and overspeed check
  always_comb begin
    pprod_c = PPROD_W'(err) * PPROD_W'($signed({1'b0, cfg.prop_gain}));
    over_c  = ERR_W'(speed_c) >
              (ERR_W'(set_speed) + ERR_W'($signed({1'b0, cfg.overspeed_margin})));
  end

  // integral state, moves once per transfer into stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (ctl.integ_upd) begin
      integral <= integral_next;
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      set2   <= set_speed;
      speed2 <= speed_c;
      pprod2 <= pprod_c;
      over2  <= over_c;
    end
  end

  // stage 3: pi sum in thousandths, zero on overspeed
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      speed <= speed2;
      if (over2) begin
        ctrl <= '0;
      end else begin
        ctrl <= CTRL_W'(set2) * MILLI_S + CTRL_W'(pprod2) * PSCALE_S + CTRL_W'(integral);
      end
    end
  end

  `PSL_ASSERT_ALWAYS(a_integ_range, (integral <= INTEG_HI) && (integral >= -INTEG_HI), "integral out of range")
  `PSL_ASSERT_NEXT(a_integ_hold, !ctl.integ_upd, $stable(integral), "integral moved without a transfer")

endmodule

@@ rtl/core/psl_drive.sv @@
// one wheel drive: steering offset, deadzone, saturation, magnitude and sign
module psl_drive
  import psl_pkg::*;
(
  input  logic                      clk,
  input  psl_ctl_t                  ctl,
  input  logic signed [CTRL_W-1:0]  ctrl,
  input  logic signed [STEER_W:0]   offset,
  input  logic [DZ_W-1:0]           deadzone,
  input  logic [DRV_W-1:0]          max_forward,
  input  logic [DRV_W-1:0]          max_reverse,
  output logic [DRV_W-1:0]          duty,
  output logic                      reverse
);

  localparam logic signed [CTRL_W-1:0] MILLI_S = CTRL_W'(MILLI);
  localparam int PROD_W = DRV_ABS_W + DRV_RECIP_W;

  logic signed [CTRL_W-1:0] v0;
  logic [CTRL_W-1:0]        av;
  logic [PROD_W-1:0]        prod;
  logic [DRV_Q_W-1:0]       qd;
  logic [DRV_W-1:0]         duty_next;
  logic                     reverse_next;

  logic [DRV_ABS_W-1:0]     abs4;
  logic                     neg4;
  logic                     nz4;
  logic [DRV_Q_W-1:0]       q5;
  logic                     neg5;
  logic                     nz5;

  // drive in thousandths and its magnitude
  always_comb begin
    v0 = ctrl + CTRL_W'(offset) * MILLI_S;
    av = (v0 < 0) ? -v0 : v0;
  end

  // stage 4: sign, nonzero flag, magnitude clamped past every limit
  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      neg4 <= v0 < 0;
      nz4  <= v0 != 0;
      abs4 <= (av >= CTRL_W'(DRV_ABS_MAX)) ? DRV_ABS_W'(DRV_ABS_MAX)
                                           : av[DRV_ABS_W-1:0];
    end
  end

  // stage 5: whole units by reciprocal multiply
  assign prod = PROD_W'(abs4) * PROD_W'(DRV_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      q5   <= prod[DRV_SHIFT +: DRV_Q_W];
      neg5 <= neg4;
      nz5  <= nz4;
    end
  end

  // deadzone added when nonzero, then reverse or forward limit by sign
  always_comb begin
    qd = q5 + (nz5 ? DRV_Q_W'(deadzone) : DRV_Q_W'(0));
    if (neg5) begin
      if (qd >= DRV_Q_W'(max_reverse)) begin
        duty_next    = max_reverse;
        reverse_next = max_reverse != '0;
      end else begin
        duty_next    = qd[DRV_W-1:0];
        reverse_next = 1'b1;
      end
    end else begin
      reverse_next = 1'b0;
      if (qd >= DRV_Q_W'(max_forward)) begin
        duty_next = max_forward;
      end else begin
        duty_next = qd[DRV_W-1:0];
      end
    end
  end

  // stage 6: result register
  always_ff @(posedge clk) begin
    if (ctl.ld6) begin
      duty    <= duty_next;
      reverse <= reverse_next;
    end
  end

endmodule

@@ rtl/core/psl_cv.sv @@
// control value: pi sum in whole units, truncated toward zero and saturated
module psl_cv
  import psl_pkg::*;
(
  input  logic                     clk,
  input  psl_ctl_t                 ctl,
  input  logic signed [CTRL_W-1:0] ctrl,
  output logic signed [CV_W-1:0]   control_value
);

  localparam int PROD_W = CV_ABS_W + CV_RECIP_W;

  logic [CTRL_W-1:0]     av;
  logic [PROD_W-1:0]     prod;
  logic [CV_W-1:0]       cv_next;

  logic [CV_ABS_W-1:0]   abs4;
  logic                  neg4;
  logic [CV_Q_W-1:0]     q5;
  logic                  neg5;

  assign av = (ctrl < 0) ? -ctrl : ctrl;

  // stage 4: sign and clamped magnitude
  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      neg4 <= ctrl < 0;
      abs4 <= (av >= CTRL_W'(CV_ABS_MAX)) ? CV_ABS_W'(CV_ABS_MAX) : av[CV_ABS_W-1:0];
    end
  end

  // stage 5: divide by 1000 through reciprocal multiply
  assign prod = PROD_W'(abs4) * PROD_W'(CV_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      q5   <= prod[CV_SHIFT +: CV_Q_W];
      neg5 <= neg4;
    end
  end

  // restore sign, saturate the positive side
  always_comb begin
    if (neg5) begin
      cv_next = CV_W'(0) - CV_W'(q5);
    end else if (q5 > CV_Q_W'(CV_POS_MAX)) begin
      cv_next = CV_W'(CV_POS_MAX);
    end else begin
      cv_next = CV_W'(q5);
    end
  end

  // stage 6: result register
  always_ff @(posedge clk) begin
    if (ctl.ld6) begin
      control_value <= $signed(cv_next);
    end
  end

endmodule

@@ rtl/core/pi_speed_loop_dual_motor.sv @@
// Dual motor PI speed loop, top level.
//
// Input channel (in_valid / in_stall) carries one control tick: two encoder
// counts, a set speed and a steering difference. Output channel
// (out_valid / out_stall) returns one result per tick: both wheel duties with
// reverse flags, the measured speed and the control value.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
// taken on any edge out of reset with cfg_write high.
//
// Throughput is one tick per cycle unless the receiver stalls. A result passes
// from its input transfer through the input register, error and integral
// stage, pi sum, magnitude clamp, reciprocal divide by 1000 and result
// register. The integral is updated as its tick enters stage 2, so the next
// tick may follow directly.
//
// Reset clears the integral, loads the default gains and limits and empties
// the pipeline. When the receiver stalls, the result register holds and
// stages behind it keep filling their empty slots; in_stall rises only once
// every stage holds a tick.
`include "pi_speed_loop_dual_motor_defines.svh"

module pi_speed_loop_dual_motor
  import psl_pkg::*;
#(
  parameter int SPEED_CLAMP = DEF_SPEED_CLAMP
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CNT_W-1:0]     left_count,
  input  logic signed [CNT_W-1:0]     right_count,
  input  logic signed [SET_W-1:0]     set_speed,
  input  logic signed [STEER_W-1:0]   steer_diff,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [DRV_W-1:0]            left_duty,
  output logic                        left_reverse,
  output logic [DRV_W-1:0]            right_duty,
  output logic                        right_reverse,
  output logic signed [SPD_OUT_W-1:0] measured_speed,
  output logic signed [CV_W-1:0]      control_value
);

  psl_cfg_t cfg;
  psl_ctl_t ctl;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic signed [CNT_W-1:0]   lc1;
  logic signed [CNT_W-1:0]   rc1;
  logic signed [SET_W-1:0]   set1;
  logic signed [STEER_W-1:0] steer1;
  logic signed [STEER_W-1:0] steer2;
  logic signed [STEER_W-1:0] steer3;
  logic signed [SPD_W-1:0]   speed3;
  logic signed [SPD_W-1:0]   speed4;
  logic signed [SPD_W-1:0]   speed5;
  logic signed [CTRL_W-1:0]  ctrl3;
  logic signed [STEER_W:0]   off_left;
  logic signed [STEER_W:0]   off_right;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= RST_PROP_GAIN;
      cfg.integ_gain       <= RST_INTEG_GAIN;
      cfg.integ_limit      <= RST_INTEG_LIM;
      cfg.overspeed_margin <= RST_MARGIN;
      cfg.left_deadzone    <= RST_LEFT_DZ;
      cfg.right_deadzone   <= RST_RIGHT_DZ;
      cfg.max_forward      <= RST_MAX_FWD;
      cfg.max_reverse      <= RST_MAX_REV;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:  cfg.prop_gain        <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain       <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIM:  cfg.integ_limit      <= cfg_data[LIMIT_W-1:0];
        REG_MARGIN:     cfg.overspeed_margin <= cfg_data[MARGIN_W-1:0];
        REG_LEFT_DZ:    cfg.left_deadzone    <= cfg_data[DZ_W-1:0];
        REG_RIGHT_DZ:   cfg.right_deadzone   <= cfg_data[DZ_W-1:0];
        REG_MAX_FWD:    cfg.max_forward      <= cfg_data[DRV_W-1:0];
        REG_MAX_REV:    cfg.max_reverse      <= cfg_data[DRV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a stage takes a new tick when empty or when it passes its own on
  always_comb begin
    rdy6 = !out_valid || !out_stall;
    rdy5 = !v5 || rdy6;
    rdy4 = !v4 || rdy5;
    rdy3 = !v3 || rdy4;
    rdy2 = !v2 || rdy3;
    rdy1 = !v1 || rdy2;
    in_stall      = !rdy1;
    ctl.ld2       = rdy2;
    ctl.ld3       = rdy3;
    ctl.ld4       = rdy4;
    ctl.ld5       = rdy5;
    ctl.ld6       = rdy6;
    ctl.integ_upd = v1 && rdy2;
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) out_valid <= v5;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      lc1    <= left_count;
      rc1    <= right_count;
      set1   <= set_speed;
      steer1 <= steer_diff;
    end
  end

  // steering and measured speed ride alongside the pi path
  always_ff @(posedge clk) begin
    if (rdy2) steer2 <= steer1;
    if (rdy3) steer3 <= steer2;
    if (rdy4) speed4 <= speed3;
    if (rdy5) speed5 <= speed4;
    if (rdy6) measured_speed <= speed5[SPD_OUT_W-1:0];
  end

  psl_pi_core #(
    .SPEED_CLAMP (SPEED_CLAMP)
  ) u_pi_core (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg         (cfg),
    .left_count  (lc1),
    .right_count (rc1),
    .set_speed   (set1),
    .ctrl        (ctrl3),
    .speed       (speed3)
  );

  // steering added left, subtracted right
  assign off_left  = (STEER_W+1)'(steer3);
  assign off_right = -((STEER_W+1)'(steer3));

  psl_drive u_drive_left (
    .clk         (clk),
    .ctl         (ctl),
    .ctrl        (ctrl3),
    .offset      (off_left),
    .deadzone    (cfg.left_deadzone),
    .max_forward (cfg.max_forward),
    .max_reverse (cfg.max_reverse),
    .duty        (left_duty),
    .reverse     (left_reverse)
  );

  psl_drive u_drive_right (
    .clk         (clk),
    .ctl         (ctl),
    .ctrl        (ctrl3),
    .offset      (off_right),
    .deadzone    (cfg.right_deadzone),
    .max_forward (cfg.max_forward),
    .max_reverse (cfg.max_reverse),
    .duty        (right_duty),
    .reverse     (right_reverse)
  );

  psl_cv u_cv (
    .clk           (clk),
    .ctl           (ctl),
    .ctrl          (ctrl3),
    .control_value (control_value)
  );

  `PSL_ASSERT_IMPL(a_stall_full, in_stall, v1 && v2 && v3 && v4 && v5 && out_valid && out_stall, "input stalled with a free stage")
  `PSL_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v1, "accepted tick lost at input register")

endmodule
